// File: rtl/onewire_bus_master_macros.svh
// assertion helpers for the 1-wire bus master
`ifndef ONEWIRE_BUS_MASTER_MACROS_SVH
`define ONEWIRE_BUS_MASTER_MACROS_SVH

// clocked assertion with asynchronous active-low reset disable
`define OWBM_ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same on the block's own clock and reset
`define OWBM_ASSERT(label, prop, msg) \
	`OWBM_ASSERT_CLK(label, clk, arst_n, prop, msg)

`endif

// File: rtl/owbm_pkg.sv
`timescale 1ns / 1ps
package owbm_pkg;

	// wait counter width
	localparam int WAIT_W = 10;
	localparam int CFG_W = 10;
	localparam int EXT_W = (CFG_W > WAIT_W) ? CFG_W : WAIT_W;
	localparam int IDX_W = 4;

	// request codes
	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_RESET = 2'd1;
	localparam logic [1:0] REQ_WRITE = 2'd2;
	localparam logic [1:0] REQ_READ  = 2'd3;

	// register indexes
	localparam logic [IDX_W-1:0] REG_RESET_LOW   = 4'd0;
	localparam logic [IDX_W-1:0] REG_PRES_WAIT   = 4'd1;
	localparam logic [IDX_W-1:0] REG_RESET_TAIL  = 4'd2;
	localparam logic [IDX_W-1:0] REG_SLOT        = 4'd3;
	localparam logic [IDX_W-1:0] REG_RECOVERY    = 4'd4;
	localparam logic [IDX_W-1:0] REG_READ_SAMPLE = 4'd5;
	localparam logic [IDX_W-1:0] REG_WRITE_LOW   = 4'd6;
	localparam logic [IDX_W-1:0] REG_READ_LOW    = 4'd7;

	// phase codes
	localparam logic [3:0] PH_IDLE        = 4'd0;
	localparam logic [3:0] PH_RST_LOW     = 4'd1;
	localparam logic [3:0] PH_RST_RELEASE = 4'd2;
	localparam logic [3:0] PH_RST_SAMPLE  = 4'd3;
	localparam logic [3:0] PH_RST_END     = 4'd4;
	localparam logic [3:0] PH_WR_LOW      = 4'd5;
	localparam logic [3:0] PH_WR_DATA     = 4'd6;
	localparam logic [3:0] PH_WR_RECOVER  = 4'd7;
	localparam logic [3:0] PH_WR_END      = 4'd8;
	localparam logic [3:0] PH_RD_LOW      = 4'd9;
	localparam logic [3:0] PH_RD_RELEASE  = 4'd10;
	localparam logic [3:0] PH_RD_SAMPLE   = 4'd11;
	localparam logic [3:0] PH_RD_NEXT     = 4'd12;

	localparam logic [CFG_W-1:0] START_WAIT = 10'd3;
	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	typedef struct packed {
		logic [CFG_W-1:0] reset_low_us;
		logic [CFG_W-1:0] presence_wait_us;
		logic [CFG_W-1:0] reset_tail_us;
		logic [CFG_W-1:0] slot_us;
		logic [CFG_W-1:0] recovery_us;
		logic [CFG_W-1:0] read_sample_us;
		logic [CFG_W-1:0] write_low_us;
		logic [CFG_W-1:0] read_low_us;
	} cfg_t;

	typedef struct packed {
		logic       pin_drive_enable;
		logic       pin_level;
		logic       busy_res;
		logic       cmd_rejected;
		logic       op_done;
		logic [7:0] read_byte;
		logic       device_present;
	} res_t;

	// saturate a register value into the wait counter range
	function automatic logic [WAIT_W-1:0] sat_wait(input logic [CFG_W-1:0] v);
		logic [EXT_W-1:0] v_ext;
		logic [EXT_W-1:0] max_ext;
		logic [EXT_W-1:0] r;
		v_ext = EXT_W'(v);
		max_ext = EXT_W'({WAIT_W{1'b1}});
		r = (v_ext > max_ext) ? max_ext : v_ext;
		return r[WAIT_W-1:0];
	endfunction

endpackage

// File: rtl/owbm_cfg_regs.sv
`timescale 1ns / 1ps
module owbm_cfg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [owbm_pkg::IDX_W-1:0]  wr_index,
	input  logic [owbm_pkg::CFG_W-1:0]  wr_data,
	output owbm_pkg::cfg_t              cfg
);

	owbm_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reset_low_us     <= 10'd480;
			cfg_q.presence_wait_us <= 10'd70;
			cfg_q.reset_tail_us    <= 10'd410;
			cfg_q.slot_us          <= 10'd60;
			cfg_q.recovery_us      <= 10'd10;
			cfg_q.read_sample_us   <= 10'd5;
			cfg_q.write_low_us     <= 10'd2;
			cfg_q.read_low_us      <= 10'd1;
		end else if (wr_en) begin
			unique case (wr_index)
				owbm_pkg::REG_RESET_LOW:   cfg_q.reset_low_us     <= wr_data;
				owbm_pkg::REG_PRES_WAIT:   cfg_q.presence_wait_us <= wr_data;
				owbm_pkg::REG_RESET_TAIL:  cfg_q.reset_tail_us    <= wr_data;
				owbm_pkg::REG_SLOT:        cfg_q.slot_us          <= wr_data;
				owbm_pkg::REG_RECOVERY:    cfg_q.recovery_us      <= wr_data;
				owbm_pkg::REG_READ_SAMPLE: cfg_q.read_sample_us   <= wr_data;
				owbm_pkg::REG_WRITE_LOW:   cfg_q.write_low_us     <= wr_data;
				owbm_pkg::REG_READ_LOW:    cfg_q.read_low_us      <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/owbm_core.sv
`timescale 1ns / 1ps
module owbm_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           fire,
	input  logic [1:0]     req_type,
	input  logic [7:0]     write_byte,
	input  logic           line_level,
	input  owbm_pkg::cfg_t cfg,
	output owbm_pkg::res_t res
);

	logic [3:0]                  phase_q, phase_d;
	logic [owbm_pkg::WAIT_W-1:0] wait_q, wait_d, wait_dec;
	logic                        origin_q, origin_d;
	logic [7:0]                  shift_q, shift_d;
	logic [3:0]                  bits_q, bits_d, bits_dec, wr_pos;
	logic                        busy_q, busy_d;
	logic                        pres_q, pres_d;
	logic                        den_q, den_d;
	logic                        dlv_q, dlv_d;
	logic                        proceed, rejected, done;

	assign wait_dec = wait_q - owbm_pkg::WAIT_W'(1);
	assign bits_dec = bits_q - 4'd1;
	assign wr_pos   = owbm_pkg::BITS_PER_BYTE - bits_q;

	always_comb begin
		phase_d  = phase_q;
		wait_d   = wait_q;
		origin_d = origin_q;
		shift_d  = shift_q;
		bits_d   = bits_q;
		busy_d   = busy_q;
		pres_d   = pres_q;
		den_d    = den_q;
		dlv_d    = dlv_q;
		proceed  = 1'b1;
		rejected = 1'b0;
		done     = 1'b0;
		if (req_type == owbm_pkg::REQ_TICK) begin
			// first tick after a start marks the time origin and does not count the wait down
			if (origin_q) begin
				origin_d = 1'b0;
				if (wait_q != '0) proceed = 1'b0;
			end else if (wait_q != '0) begin
				wait_d = wait_dec;
				if (wait_dec != '0) proceed = 1'b0;
			end
			if (proceed) begin
				unique case (phase_q)
					owbm_pkg::PH_IDLE: ;
					owbm_pkg::PH_RST_LOW: begin
						den_d   = 1'b1;
						dlv_d   = 1'b0;
						wait_d  = owbm_pkg::sat_wait(cfg.reset_low_us);
						phase_d = owbm_pkg::PH_RST_RELEASE;
					end
					owbm_pkg::PH_RST_RELEASE: begin
						den_d   = 1'b0;
						wait_d  = owbm_pkg::sat_wait(cfg.presence_wait_us);
						phase_d = owbm_pkg::PH_RST_SAMPLE;
					end
					owbm_pkg::PH_RST_SAMPLE: begin
						pres_d  = line_level;
						wait_d  = owbm_pkg::sat_wait(cfg.reset_tail_us);
						phase_d = owbm_pkg::PH_RST_END;
					end
					owbm_pkg::PH_WR_LOW: begin
						den_d   = 1'b1;
						dlv_d   = 1'b0;
						wait_d  = owbm_pkg::sat_wait(cfg.write_low_us);
						phase_d = owbm_pkg::PH_WR_DATA;
					end
					owbm_pkg::PH_WR_DATA: begin
						// a one releases the line early
						if (shift_q[wr_pos[2:0]]) den_d = 1'b0;
						wait_d  = owbm_pkg::sat_wait(cfg.slot_us);
						phase_d = owbm_pkg::PH_WR_RECOVER;
					end
					owbm_pkg::PH_WR_RECOVER: begin
						den_d   = 1'b0;
						wait_d  = owbm_pkg::sat_wait(cfg.recovery_us);
						bits_d  = bits_dec;
						phase_d = (bits_dec != 4'd0) ? owbm_pkg::PH_WR_LOW
							: owbm_pkg::PH_WR_END;
					end
					owbm_pkg::PH_RD_LOW: begin
						den_d   = 1'b1;
						dlv_d   = 1'b0;
						wait_d  = owbm_pkg::sat_wait(cfg.read_low_us);
						phase_d = owbm_pkg::PH_RD_RELEASE;
					end
					owbm_pkg::PH_RD_RELEASE: begin
						den_d   = 1'b0;
						wait_d  = owbm_pkg::sat_wait(cfg.read_sample_us);
						phase_d = owbm_pkg::PH_RD_SAMPLE;
					end
					owbm_pkg::PH_RD_SAMPLE: begin
						shift_d = {line_level, shift_q[7:1]};
						wait_d  = owbm_pkg::sat_wait(cfg.slot_us);
						phase_d = owbm_pkg::PH_RD_NEXT;
					end
					owbm_pkg::PH_RD_NEXT: begin
						bits_d = bits_dec;
						if (bits_dec != 4'd0) begin
							phase_d = owbm_pkg::PH_RD_LOW;
						end else begin
							phase_d = owbm_pkg::PH_IDLE;
							busy_d  = 1'b0;
							done    = 1'b1;
						end
					end
					owbm_pkg::PH_RST_END, owbm_pkg::PH_WR_END: begin
						phase_d = owbm_pkg::PH_IDLE;
						busy_d  = 1'b0;
						done    = 1'b1;
					end
					default: begin
						// undefined phase code: back to idle without done
						phase_d = owbm_pkg::PH_IDLE;
						busy_d  = 1'b0;
					end
				endcase
			end
		end else if (busy_q) begin
			rejected = 1'b1;
		end else begin
			unique case (req_type)
				owbm_pkg::REQ_RESET: begin
					den_d   = 1'b1;
					dlv_d   = 1'b1;
					wait_d  = owbm_pkg::sat_wait(owbm_pkg::START_WAIT);
					phase_d = owbm_pkg::PH_RST_LOW;
					pres_d  = 1'b1;
				end
				owbm_pkg::REQ_WRITE: begin
					bits_d  = owbm_pkg::BITS_PER_BYTE;
					shift_d = write_byte;
					phase_d = owbm_pkg::PH_WR_LOW;
				end
				owbm_pkg::REQ_READ: begin
					shift_d = 8'd0;
					bits_d  = owbm_pkg::BITS_PER_BYTE;
					phase_d = owbm_pkg::PH_RD_LOW;
				end
				default: ;
			endcase
			origin_d = 1'b1;
			busy_d   = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= owbm_pkg::PH_IDLE;
			wait_q   <= '0;
			origin_q <= 1'b0;
			shift_q  <= 8'd0;
			bits_q   <= 4'd0;
			busy_q   <= 1'b0;
			pres_q   <= 1'b1;
			den_q    <= 1'b0;
			dlv_q    <= 1'b1;
		end else if (fire) begin
			phase_q  <= phase_d;
			wait_q   <= wait_d;
			origin_q <= origin_d;
			shift_q  <= shift_d;
			bits_q   <= bits_d;
			busy_q   <= busy_d;
			pres_q   <= pres_d;
			den_q    <= den_d;
			dlv_q    <= dlv_d;
		end
	end

	assign res.pin_drive_enable = den_d;
	assign res.pin_level        = dlv_d;
	assign res.busy_res         = busy_d;
	assign res.cmd_rejected     = rejected;
	assign res.op_done          = done;
	assign res.read_byte        = shift_d;
	assign res.device_present   = ~pres_d;

endmodule

// File: rtl/onewire_bus_master.sv
`timescale 1ns / 1ps
// 1-wire bus master, advanced by one-microsecond tick beats on the input channel.
// input beat: req_type (tick, start reset, start write, start read), write_byte,
// line_level (bus level sampled for this beat; used only on sampling ticks).
// every input beat yields exactly one output beat with the pin controls, busy,
// reject and done flags, the byte register and the presence flag.
// a start beat while busy is rejected and changes nothing; ticks while idle do nothing.
// config port: cfg_index / cfg_data write the eight wait registers; cfg_ready is
// always high. write only while no beat is in flight.
// an accepted input beat is registered and shows on the output in the next cycle.
// throughput: one beat per cycle unless the receiver stalls; the whole update for a beat is one pass of
// sequencer logic into the state registers and the output register.
// when the receiver stalls, in_ready follows out_ready so a held result is never
// overwritten; the next beat is taken in the same cycle the held one drains.
// reset: phase idle, line released, level register high, no device present,
// wait registers at their default timings, output channel empty.
module onewire_bus_master (
	input  logic                        clk,
	input  logic                        arst_n,
	// input channel
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  req_type,
	input  logic [7:0]                  write_byte,
	input  logic                        line_level,
	// output channel
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        pin_drive_enable,
	output logic                        pin_level,
	output logic                        busy_res,
	output logic                        cmd_rejected,
	output logic                        op_done,
	output logic [7:0]                  read_byte,
	output logic                        device_present,
	// config write channel
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [owbm_pkg::IDX_W-1:0]  cfg_index,
	input  logic [owbm_pkg::CFG_W-1:0]  cfg_data
);

	owbm_pkg::cfg_t cfg;
	owbm_pkg::res_t res_next;
	owbm_pkg::res_t res_q;
	logic           out_valid_q;
	logic           fire;

	// output register empty or draining this cycle
	assign in_ready  = ~out_valid_q | out_ready;
	assign fire      = in_valid & in_ready;
	assign cfg_ready = 1'b1;

	owbm_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// phase sequencer and bus state
	owbm_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.req_type   (req_type),
		.write_byte (write_byte),
		.line_level (line_level),
		.cfg        (cfg),
		.res        (res_next)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res_next;
		end
	end

	assign out_valid        = out_valid_q;
	assign pin_drive_enable = res_q.pin_drive_enable;
	assign pin_level        = res_q.pin_level;
	assign busy_res         = res_q.busy_res;
	assign cmd_rejected     = res_q.cmd_rejected;
	assign op_done          = res_q.op_done;
	assign read_byte        = res_q.read_byte;
	assign device_present   = res_q.device_present;

endmodule

// File: rtl/owbm_checker.sv
`timescale 1ns / 1ps
`include "onewire_bus_master_macros.svh"
module owbm_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic busy_res,
	input logic cmd_rejected,
	input logic op_done
);

	// stalled result beat is held
	`OWBM_ASSERT(a_out_hold, (out_valid && !out_ready) |=> out_valid, "output beat dropped")

	// every accepted input beat yields an output beat next cycle
	`OWBM_ASSERT(a_in_to_out, (in_valid && in_ready) |=> out_valid, "missing result beat")

	// completion leaves the block ready
	`OWBM_ASSERT(a_done_ready, (out_valid && op_done) |-> !busy_res, "busy after done")

	// a reject only happens while busy, and never with done
	`OWBM_ASSERT(a_rej_busy, (out_valid && cmd_rejected) |-> (busy_res && !op_done), "bad reject")

endmodule

bind onewire_bus_master owbm_checker u_owbm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.busy_res     (busy_res),
	.cmd_rejected (cmd_rejected),
	.op_done      (op_done)
);

// File: sim/onewire_bus_master_tb.sv
`timescale 1ns / 1ps
module onewire_bus_master_tb;
	import owbm_pkg::*;

	// how the stimulus drives the bus line on sampling ticks
	typedef enum logic [1:0] {
		LINE_LOW,
		LINE_HIGH,
		LINE_RANDOM
	} line_mode_e;

	// a register index past the eight wait registers, must be ignored
	localparam logic [IDX_W-1:0] REG_UNUSED_HI = 4'd15;
	localparam logic [IDX_W-1:0] REG_UNUSED_LO = 4'd8;

	localparam int RANDOM_ITEMS = 300;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int DRAIN_LIMIT = 1000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// input channel
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] req_type = REQ_TICK;
	logic [7:0] write_byte = 8'h00;
	logic line_level = 1'b1;

	// output channel
	logic out_valid;
	logic out_ready = 1'b0;
	logic pin_drive_enable;
	logic pin_level;
	logic busy_res;
	logic cmd_rejected;
	logic op_done;
	logic [7:0] read_byte;
	logic device_present;

	// config write channel
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [IDX_W-1:0] cfg_index = REG_RESET_LOW;
	logic [CFG_W-1:0] cfg_data = '0;

	// bus master prediction state, mirrors what the block should hold
	logic [3:0] ph;
	logic [WAIT_W-1:0] wait_cnt;
	logic origin_pending;
	logic [7:0] shreg;
	logic [3:0] bits_rem;
	logic pred_busy;
	logic pres_smp;
	logic drv_en;
	logic drv_lvl;
	logic [CFG_W-1:0] wait_reg [0:7];

	// beats the block still owes us, oldest first
	res_t expected_beats [$];
	res_t got_beat;
	res_t want_beat;
	string bad_fields;

	int mismatch_count = 0;
	int sent_items = 0;

	// traffic shaping shared between the sender and the receiver
	logic steady = 1'b0;
	int hold_cycles_req = 0;
	int hold_left = 0;

	onewire_bus_master uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.req_type         (req_type),
		.write_byte       (write_byte),
		.line_level       (line_level),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.pin_drive_enable (pin_drive_enable),
		.pin_level        (pin_level),
		.busy_res         (busy_res),
		.cmd_rejected     (cmd_rejected),
		.op_done          (op_done),
		.read_byte        (read_byte),
		.device_present   (device_present),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	// 100 MHz clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// a wait register value that does not fit the countdown is clipped to full scale
	function automatic logic [WAIT_W-1:0] wait_load(input logic [CFG_W-1:0] v);
		if (longint'(v) > (longint'(1) << WAIT_W) - 1)
			return '1;
		return WAIT_W'(v);
	endfunction

	// advance the predicted bus master by one input beat, return the beat it should emit
	function automatic res_t bus_step(input logic [1:0] req, input logic [7:0] wb,
			input logic ln);
		res_t r;
		logic go;
		logic rej;
		logic done;
		rej = 1'b0;
		done = 1'b0;
		if (req == REQ_TICK) begin
			go = 1'b1;
			// first tick after a start sets the time origin and does not count the wait down
			if (origin_pending) begin
				origin_pending = 1'b0;
				if (wait_cnt != 0)
					go = 1'b0;
			end else if (wait_cnt != 0) begin
				wait_cnt = wait_cnt - 1'b1;
				if (wait_cnt != 0)
					go = 1'b0;
			end
			if (go) begin
				case (ph)
					PH_IDLE: ;
					PH_RST_LOW: begin
						drv_en = 1'b1;
						drv_lvl = 1'b0;
						wait_cnt = wait_load(wait_reg[REG_RESET_LOW]);
						ph = PH_RST_RELEASE;
					end
					PH_RST_RELEASE: begin
						drv_en = 1'b0;
						wait_cnt = wait_load(wait_reg[REG_PRES_WAIT]);
						ph = PH_RST_SAMPLE;
					end
					PH_RST_SAMPLE: begin
						pres_smp = ln;
						wait_cnt = wait_load(wait_reg[REG_RESET_TAIL]);
						ph = PH_RST_END;
					end
					PH_WR_LOW: begin
						drv_en = 1'b1;
						drv_lvl = 1'b0;
						wait_cnt = wait_load(wait_reg[REG_WRITE_LOW]);
						ph = PH_WR_DATA;
					end
					PH_WR_DATA: begin
						// a one releases the line early, a zero keeps it low
						if (shreg[3'(BITS_PER_BYTE - bits_rem)])
							drv_en = 1'b0;
						wait_cnt = wait_load(wait_reg[REG_SLOT]);
						ph = PH_WR_RECOVER;
					end
					PH_WR_RECOVER: begin
						drv_en = 1'b0;
						wait_cnt = wait_load(wait_reg[REG_RECOVERY]);
						bits_rem = bits_rem - 1'b1;
						ph = (bits_rem != 0) ? PH_WR_LOW : PH_WR_END;
					end
					PH_RD_LOW: begin
						drv_en = 1'b1;
						drv_lvl = 1'b0;
						wait_cnt = wait_load(wait_reg[REG_READ_LOW]);
						ph = PH_RD_RELEASE;
					end
					PH_RD_RELEASE: begin
						drv_en = 1'b0;
						wait_cnt = wait_load(wait_reg[REG_READ_SAMPLE]);
						ph = PH_RD_SAMPLE;
					end
					PH_RD_SAMPLE: begin
						// lsb first, each new bit enters at the top
						shreg = {ln, shreg[7:1]};
						wait_cnt = wait_load(wait_reg[REG_SLOT]);
						ph = PH_RD_NEXT;
					end
					PH_RD_NEXT: begin
						bits_rem = bits_rem - 1'b1;
						if (bits_rem != 0) begin
							ph = PH_RD_LOW;
						end else begin
							ph = PH_IDLE;
							pred_busy = 1'b0;
							done = 1'b1;
						end
					end
					PH_RST_END, PH_WR_END: begin
						ph = PH_IDLE;
						pred_busy = 1'b0;
						done = 1'b1;
					end
					default: begin
						ph = PH_IDLE;
						pred_busy = 1'b0;
					end
				endcase
			end
		end else if (pred_busy) begin
			rej = 1'b1;
		end else begin
			case (req)
				REQ_RESET: begin
					drv_en = 1'b1;
					drv_lvl = 1'b1;
					wait_cnt = wait_load(START_WAIT);
					ph = PH_RST_LOW;
					pres_smp = 1'b1;
				end
				REQ_WRITE: begin
					bits_rem = BITS_PER_BYTE;
					shreg = wb;
					ph = PH_WR_LOW;
				end
				default: begin
					shreg = 8'h00;
					bits_rem = BITS_PER_BYTE;
					ph = PH_RD_LOW;
				end
			endcase
			origin_pending = 1'b1;
			pred_busy = 1'b1;
		end
		r.pin_drive_enable = drv_en;
		r.pin_level = drv_lvl;
		r.busy_res = pred_busy;
		r.cmd_rejected = rej;
		r.op_done = done;
		r.read_byte = shreg;
		r.device_present = ~pres_smp;
		return r;
	endfunction

	task automatic flag_mismatch(input string why, input res_t want, input res_t got);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("mismatch at %0t:%s", $realtime, why);
			$display("  expected de=%b lvl=%b busy=%b rej=%b done=%b byte=%h pres=%b",
				want.pin_drive_enable, want.pin_level, want.busy_res, want.cmd_rejected,
				want.op_done, want.read_byte, want.device_present);
			$display("  actual   de=%b lvl=%b busy=%b rej=%b done=%b byte=%h pres=%b",
				got.pin_drive_enable, got.pin_level, got.busy_res, got.cmd_rejected,
				got.op_done, got.read_byte, got.device_present);
		end
	endtask

	// result checker: every output beat against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			got_beat.pin_drive_enable = pin_drive_enable;
			got_beat.pin_level = pin_level;
			got_beat.busy_res = busy_res;
			got_beat.cmd_rejected = cmd_rejected;
			got_beat.op_done = op_done;
			got_beat.read_byte = read_byte;
			got_beat.device_present = device_present;
			if (expected_beats.size() == 0) begin
				flag_mismatch(" beat with nothing expected", '0, got_beat);
			end else begin
				want_beat = expected_beats.pop_front();
				bad_fields = "";
				if (got_beat.pin_drive_enable !== want_beat.pin_drive_enable)
					bad_fields = {bad_fields, " pin_drive_enable"};
				if (got_beat.pin_level !== want_beat.pin_level)
					bad_fields = {bad_fields, " pin_level"};
				if (got_beat.busy_res !== want_beat.busy_res)
					bad_fields = {bad_fields, " busy_res"};
				if (got_beat.cmd_rejected !== want_beat.cmd_rejected)
					bad_fields = {bad_fields, " cmd_rejected"};
				if (got_beat.op_done !== want_beat.op_done)
					bad_fields = {bad_fields, " op_done"};
				if (got_beat.read_byte !== want_beat.read_byte)
					bad_fields = {bad_fields, " read_byte"};
				if (got_beat.device_present !== want_beat.device_present)
					bad_fields = {bad_fields, " device_present"};
				if (bad_fields != "")
					flag_mismatch(bad_fields, want_beat, got_beat);
			end
		end
	end

	// receiver: random stalls, a steady stretch, and an occasional long hold-off
	always @(posedge clk) begin
		if (hold_cycles_req != 0) begin
			hold_left = hold_cycles_req;
			hold_cycles_req = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= steady || ($urandom_range(99) >= 32);
		end
	end

	// offer one beat, with a random gap in front, and wait for it to be taken
	task automatic send_item(input logic [1:0] req, input logic [7:0] wb, input logic ln);
		if (!steady && $urandom_range(99) < 32) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= req;
		write_byte <= wb;
		line_level <= ln;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		expected_beats.push_back(bus_step(req, wb, ln));
		sent_items++;
	endtask

	// ticks until the running command completes, optionally peppered
	// with starts that must be rejected while busy
	task automatic finish_op(input line_mode_e lm, input int noise_pct);
		logic ln;
		while (pred_busy) begin
			ln = (lm == LINE_RANDOM) ? 1'($urandom) : (lm == LINE_HIGH);
			if ($urandom_range(99) < noise_pct)
				send_item(REQ_RESET + 2'($urandom_range(2)), 8'($urandom), ln);
			else
				send_item(REQ_TICK, 8'($urandom), ln);
		end
	endtask

	// one command followed by ticks until it completes
	task automatic run_op(input logic [1:0] req, input logic [7:0] wb, input line_mode_e lm,
			input int noise_pct);
		send_item(req, wb, 1'($urandom));
		finish_op(lm, noise_pct);
	endtask

	// stop offering and let every owed output beat drain
	task automatic drain_output();
		in_valid <= 1'b0;
		@(posedge clk);
		for (int n = 0; n < DRAIN_LIMIT && expected_beats.size() != 0; n++)
			@(posedge clk);
		while (expected_beats.size() != 0)
			flag_mismatch(" expected beat never arrived", expected_beats.pop_front(), '0);
		repeat (8) @(posedge clk);
	endtask

	// finish any running command, stop offering and let the output drain
	task automatic settle_bus();
		while (pred_busy) send_item(REQ_TICK, 8'($urandom), 1'($urandom));
		drain_output();
	endtask

	// one config beat; the valid stays up across back-to-back writes
	task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data,
			input logic last);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx <= REG_READ_LOW)
			wait_reg[idx] = data;
		if (last)
			cfg_valid <= 1'b0;
	endtask

	// load all eight wait registers once no beat is in flight; a command may still run
	task automatic load_timing(input cfg_t t);
		drain_output();
		for (int i = 0; i < 8; i++)
			cfg_write(IDX_W'(i), t[(7 - i) * CFG_W +: CFG_W], i == 7);
	endtask

	// load all eight wait registers while the block is idle
	task automatic apply_timing(input cfg_t t);
		while (pred_busy) send_item(REQ_TICK, 8'($urandom), 1'($urandom));
		load_timing(t);
	endtask

	// idle ticks, then the first slot of a read at the power-up timings;
	// the rest of the byte runs on short timings loaded while the read is running
	task automatic test_reset_defaults();
		send_item(REQ_TICK, 8'h00, 1'b0);
		send_item(REQ_TICK, 8'hff, 1'b1);
		send_item(REQ_READ, 8'h00, 1'b0);
		while (pred_busy && bits_rem == BITS_PER_BYTE)
			send_item(REQ_TICK, 8'($urandom), 1'($urandom));
		load_timing(cfg_t'({8{CFG_W'(1)}}));
		finish_op(LINE_RANDOM, 3);
	endtask

	// one-microsecond waits, zero recovery, both data extremes and both presence outcomes
	task automatic test_min_timing();
		cfg_t t;
		t = cfg_t'({8{CFG_W'(1)}});
		t.recovery_us = '0;
		apply_timing(t);
		run_op(REQ_WRITE, 8'hff, LINE_RANDOM, 0);
		run_op(REQ_WRITE, 8'h00, LINE_RANDOM, 0);
		run_op(REQ_READ, 8'h00, LINE_HIGH, 0);
		run_op(REQ_READ, 8'h00, LINE_LOW, 0);
		run_op(REQ_RESET, 8'h00, LINE_HIGH, 0);
		run_op(REQ_RESET, 8'h00, LINE_LOW, 20);
	endtask

	// every wait register zero: each phase runs on the very next tick, but for the start wait of a reset
	task automatic test_zero_timing();
		apply_timing(cfg_t'('0));
		run_op(REQ_WRITE, 8'h5a, LINE_RANDOM, 20);
		run_op(REQ_READ, 8'h00, LINE_RANDOM, 20);
		run_op(REQ_RESET, 8'h00, LINE_RANDOM, 20);
	endtask

	// writes past the last register must leave all timings alone
	task automatic test_unused_index();
		cfg_t t;
		t = cfg_t'({8{CFG_W'(2)}});
		apply_timing(t);
		cfg_write(REG_UNUSED_HI, '1, 1'b0);
		cfg_write(REG_UNUSED_LO, '0, 1'b1);
		run_op(REQ_READ, 8'h00, LINE_RANDOM, 5);
	endtask

	// receiver goes quiet for a long stretch while ticks keep coming
	task automatic test_backpressure();
		apply_timing(cfg_t'({8{CFG_W'(2)}}));
		steady = 1'b1;
		hold_cycles_req = LONG_HOLD_CYCLES;
		run_op(REQ_WRITE, 8'($urandom), LINE_RANDOM, 10);
		run_op(REQ_READ, 8'h00, LINE_RANDOM, 10);
		steady = 1'b0;
	endtask

	// mostly complete commands with random content on small random timings,
	// the rest stray beats of any kind
	task automatic test_random_traffic();
		int base;
		int roll;
		cfg_t t;
		base = sent_items;
		while (sent_items - base < RANDOM_ITEMS) begin
			// a stretch with no idling on either side
			steady = (sent_items - base >= 80) && (sent_items - base < 160);
			roll = $urandom_range(99);
			if (roll < 6) begin
				for (int i = 0; i < 8; i++)
					t[i * CFG_W +: CFG_W] = ($urandom_range(9) == 0) ?
						CFG_W'($urandom_range(40)) : CFG_W'($urandom_range(5));
				apply_timing(t);
			end else if (roll < 18) begin
				send_item(2'($urandom), 8'($urandom), 1'($urandom));
			end else begin
				run_op(REQ_RESET + 2'($urandom_range(2)), 8'($urandom), LINE_RANDOM, 6);
			end
		end
		steady = 1'b0;
	endtask

	initial begin
		// power-up contents of the predicted block
		ph = PH_IDLE;
		wait_cnt = '0;
		origin_pending = 1'b0;
		shreg = 8'h00;
		bits_rem = 4'd0;
		pred_busy = 1'b0;
		pres_smp = 1'b1;
		drv_en = 1'b0;
		drv_lvl = 1'b1;
		wait_reg[REG_RESET_LOW] = 10'd480;
		wait_reg[REG_PRES_WAIT] = 10'd70;
		wait_reg[REG_RESET_TAIL] = 10'd410;
		wait_reg[REG_SLOT] = 10'd60;
		wait_reg[REG_RECOVERY] = 10'd10;
		wait_reg[REG_READ_SAMPLE] = 10'd5;
		wait_reg[REG_WRITE_LOW] = 10'd2;
		wait_reg[REG_READ_LOW] = 10'd1;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_min_timing();
		test_zero_timing();
		test_unused_index();
		test_backpressure();
		test_random_traffic();
		settle_bus();

		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
